// File: src/status_led_pattern_sequencer_macros.svh
// Assertion macros shared by the status LED sequencer modules
`ifndef STATUS_LED_PATTERN_SEQUENCER_MACROS_SVH
`define STATUS_LED_PATTERN_SEQUENCER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SLPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/slps_pkg.sv
// Package: pattern codes, sequence tables and shared types of the LED sequencer
package slps_pkg;

    localparam int MS_W      = 12;
    localparam int PAT_W     = 3;
    localparam int PHASE_W   = 3;
    localparam int IDX_W     = 2;
    localparam int LEVELS_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [PAT_W-1:0] PAT_OFF    = 3'd0;
    localparam logic [PAT_W-1:0] PAT_ON     = 3'd1;
    localparam logic [PAT_W-1:0] PAT_SLOW   = 3'd2;
    localparam logic [PAT_W-1:0] PAT_FAST   = 3'd3;
    localparam logic [PAT_W-1:0] PAT_BURST  = 3'd4;
    localparam logic [PAT_W-1:0] PAT_HEART  = 3'd5;
    localparam logic [PAT_W-1:0] PAT_HEARTF = 3'd6;
    localparam logic [PAT_W-1:0] PAT_URGENT = 3'd7;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST = 1'b1;

    localparam logic [MS_W-1:0] SLOW_RESET = 12'd1000;
    localparam logic [MS_W-1:0] FAST_RESET = 12'd100;

    localparam logic [PHASE_W-1:0] BURST_LEN = 3'd7;
    localparam logic [PHASE_W-1:0] BEAT_LEN  = 3'd2;

    typedef struct packed {
        logic             tick;
        logic             set;
        logic [PAT_W-1:0] pattern;
    } led_ctl_t;

    typedef struct packed {
        logic               level;
        logic [MS_W-1:0]    ms;
        logic [PHASE_W-1:0] next_phase;
    } phase_t;

    function automatic logic [MS_W-1:0] toggle_ms(
        input logic [PAT_W-1:0] pat,
        input logic [MS_W-1:0]  slow,
        input logic [MS_W-1:0]  fast
    );
        logic [MS_W-1:0] v;
        v = (pat == PAT_SLOW) ? slow : fast;
        return (v == '0) ? 12'd1 : v;
    endfunction

    // seq: 0 burst, 1 heartbeat, 2 heartbeat fast, 3 urgent
    function automatic phase_t seq_phase(
        input logic [1:0]         seq,
        input logic [PHASE_W-1:0] phase
    );
        phase_t             r;
        logic [PHASE_W-1:0] len;
        logic [PHASE_W-1:0] p;
        len = (seq == 2'd0) ? BURST_LEN : BEAT_LEN;
        p   = (phase >= len) ? '0 : phase;
        r.level = (p == 3'd0) || ((seq == 2'd0) && (p == 3'd2 || p == 3'd4));
        unique case (seq)
            2'd0:    r.ms = (p == 3'd6) ? 12'd500 : 12'd100;
            2'd1:    r.ms = (p == 3'd0) ? 12'd50 : 12'd2950;
            2'd2:    r.ms = (p == 3'd0) ? 12'd50 : 12'd1000;
            default: r.ms = (p == 3'd0) ? 12'd50 : 12'd300;
        endcase
        r.next_phase = (p + 3'd1 >= len) ? '0 : p + 3'd1;
        return r;
    endfunction

endpackage

// File: src/slps_if.sv
// Request and result channel interfaces of the LED sequencer
interface slps_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [slps_pkg::IDX_W-1:0]  led_index;
    logic [slps_pkg::PAT_W-1:0]  pattern_code;

    modport source (output valid, command, led_index, pattern_code, input ready);
    modport sink   (input valid, command, led_index, pattern_code, output ready);
endinterface

interface slps_res_if;
    logic                          valid;
    logic                          ready;
    logic [slps_pkg::LEVELS_W-1:0] led_levels;

    modport source (output valid, led_levels, input ready);
    modport sink   (input valid, led_levels, output ready);
endinterface

// File: src/slps_led_unit.sv
// One LED: pattern state, countdown and level update
`include "status_led_pattern_sequencer_macros.svh"

module slps_led_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slps_pkg::led_ctl_t            ctl,
    input  logic [slps_pkg::MS_W-1:0]     slow_ms,
    input  logic [slps_pkg::MS_W-1:0]     fast_ms,
    output logic                          level_next
);

    logic [slps_pkg::PAT_W-1:0]   pattern_reg, pattern_next;
    logic                         level_reg;
    logic [slps_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [slps_pkg::MS_W-1:0]    remain_reg, remain_next;

    always_comb
    begin
        slps_pkg::phase_t ph;
        logic             blink;
        pattern_next = pattern_reg;
        level_next   = level_reg;
        phase_next   = phase_reg;
        remain_next  = remain_reg;
        ph           = '0;
        blink        = 1'b0;
        if (ctl.set && ctl.pattern != pattern_reg)
        begin
            pattern_next = ctl.pattern;
            if (ctl.pattern == slps_pkg::PAT_OFF || ctl.pattern == slps_pkg::PAT_ON)
            begin
                level_next  = (ctl.pattern == slps_pkg::PAT_ON);
                remain_next = '0;
            end
            else if (ctl.pattern == slps_pkg::PAT_SLOW || ctl.pattern == slps_pkg::PAT_FAST)
            begin
                level_next  = 1'b1;
                remain_next = slps_pkg::toggle_ms(ctl.pattern, slow_ms, fast_ms);
            end
            else
            begin
                ph          = slps_pkg::seq_phase(ctl.pattern[1:0], '0);
                level_next  = ph.level;
                remain_next = ph.ms;
                phase_next  = ph.next_phase;
            end
        end
        else if (ctl.tick && pattern_reg != slps_pkg::PAT_OFF
                 && pattern_reg != slps_pkg::PAT_ON)
        begin
            blink = (pattern_reg == slps_pkg::PAT_SLOW || pattern_reg == slps_pkg::PAT_FAST);
            if (remain_reg > 12'd1)
            begin
                remain_next = remain_reg - 12'd1;
            end
            else if (blink)
            begin
                level_next  = ~level_reg;
                remain_next = slps_pkg::toggle_ms(pattern_reg, slow_ms, fast_ms);
            end
            else
            begin
                ph          = slps_pkg::seq_phase(pattern_reg[1:0], phase_reg);
                level_next  = ph.level;
                remain_next = ph.ms;
                phase_next  = ph.next_phase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= slps_pkg::PAT_OFF;
            level_reg   <= 1'b0;
            phase_reg   <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            pattern_reg <= pattern_next;
            level_reg   <= level_next;
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
        end
    end

    `SLPS_ASSERT_IMP(a_static_no_count,
        pattern_reg == slps_pkg::PAT_OFF || pattern_reg == slps_pkg::PAT_ON,
        remain_reg == '0, "off/on LED has a running countdown")
    `SLPS_ASSERT_IMP(a_timed_count_live,
        pattern_reg != slps_pkg::PAT_OFF && pattern_reg != slps_pkg::PAT_ON,
        remain_reg != '0, "timed LED countdown at zero")
    `SLPS_ASSERT_IMP(a_phase_range,
        pattern_reg == slps_pkg::PAT_HEART || pattern_reg == slps_pkg::PAT_HEARTF
        || pattern_reg == slps_pkg::PAT_URGENT,
        phase_reg < slps_pkg::BEAT_LEN, "heartbeat phase out of range")

endmodule

// File: src/status_led_pattern_sequencer.sv
// Status LED pattern sequencer: top level
//
// Requests arrive on a valid/ready channel: command 0 is a 1 ms tick that
// advances every timed LED, command 1 sets the pattern of LED led_index.
// Every request yields exactly one result on the result channel, holding the
// levels of LEDs 0 to 3 after that request.
// Blink half-periods come from two registers written on the cfg port
// (index 0 slow, index 1 fast); write only while no request is in flight.
// A request goes from accept into the input register, then through the LED
// update into the result register. Throughput: one request per cycle while
// the result is not stalled; all LEDs do their update in parallel.
// A stalled result holds its register; one further request waits in the
// input register, after which ready drops until the result is taken.
// Reset: all LEDs off, countdowns cleared, registers back to 1000 and 100 ms,
// both channel stages empty.
`include "status_led_pattern_sequencer_macros.svh"

module status_led_pattern_sequencer #(
    parameter int NUM_LEDS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [slps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slps_pkg::MS_W-1:0]        cfg_data,
    slps_req_if.sink                         request,
    slps_res_if.source                       result
);

    logic [slps_pkg::MS_W-1:0]     slow_reg, fast_reg;
    logic                          in_vld_reg;
    logic                          cmd_reg;
    logic [slps_pkg::IDX_W-1:0]    idx_reg;
    logic [slps_pkg::PAT_W-1:0]    pat_reg;
    logic                          out_vld_reg;
    logic [slps_pkg::LEVELS_W-1:0] levels_reg, levels_next;
    logic [NUM_LEDS-1:0]           lvl_next;
    logic                          advance;

    assign advance       = in_vld_reg && (!out_vld_reg || result.ready);
    assign request.ready = !in_vld_reg || advance;
    assign result.valid  = out_vld_reg;
    assign result.led_levels = levels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_reg <= slps_pkg::SLOW_RESET;
            fast_reg <= slps_pkg::FAST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slps_pkg::CFG_SLOW: slow_reg <= cfg_data;
                slps_pkg::CFG_FAST: fast_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (request.ready)
            begin
                in_vld_reg <= request.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            cmd_reg <= request.command;
            idx_reg <= request.led_index;
            pat_reg <= request.pattern_code;
        end
        if (advance)
        begin
            levels_reg <= levels_next;
        end
    end

    for (genvar i = 0; i < NUM_LEDS; i++)
    begin : g_led
        slps_pkg::led_ctl_t ctl;
        assign ctl.tick    = advance && (cmd_reg == slps_pkg::CMD_TICK);
        assign ctl.pattern = pat_reg;
        if (i < 4)
        begin : g_addr
            assign ctl.set = advance && (cmd_reg == slps_pkg::CMD_SET)
                             && (idx_reg == slps_pkg::IDX_W'(i));
        end
        else
        begin : g_noaddr
            assign ctl.set = 1'b0;
        end

        slps_led_unit u_led (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .slow_ms    (slow_reg),
            .fast_ms    (fast_reg),
            .level_next (lvl_next[i])
        );
    end

    for (genvar b = 0; b < slps_pkg::LEVELS_W; b++)
    begin : g_lvl
        if (b < NUM_LEDS)
        begin : g_on
            assign levels_next[b] = lvl_next[b];
        end
        else
        begin : g_off
            assign levels_next[b] = 1'b0;
        end
    end

    `SLPS_ASSERT_NEXT(a_held_request_kept, in_vld_reg && !advance, in_vld_reg,
        "held request dropped")
    `SLPS_ASSERT_NEXT(a_advance_gives_result, advance, out_vld_reg,
        "processed request produced no result")
    `SLPS_ASSERT_IMP(a_no_overwrite, out_vld_reg && !result.ready, !advance,
        "pending result overwritten")

endmodule

// File: tb/sv/status_led_pattern_sequencer_check.sv
// Request/result monitor with LED level predictor for the status LED pattern sequencer
module status_led_pattern_sequencer_check #(
    parameter int NUM_LEDS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [slps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slps_pkg::MS_W-1:0]        cfg_data,
    slps_req_if                              request,
    slps_res_if                              result,
    output int                               pending,
    output int                               mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import slps_pkg::*;

    // sequences in pattern order: burst, heartbeat, heartbeat fast, urgent
    localparam logic [PHASE_W-1:0] SEQ_LEN [4] = '{3'd7, 3'd2, 3'd2, 3'd2};
    localparam logic [MS_W-1:0] SEQ_MS [4][7] = '{
        '{12'd100, 12'd100, 12'd100, 12'd100, 12'd100, 12'd100, 12'd500},
        '{12'd50, 12'd2950, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        '{12'd50, 12'd1000, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        '{12'd50, 12'd300, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}
    };
    // bit p is the level of phase p
    localparam logic [6:0] SEQ_LEVEL [4] = '{7'b0010101, 7'b0000001, 7'b0000001, 7'b0000001};

    logic [MS_W-1:0]    slow_ms;
    logic [MS_W-1:0]    fast_ms;
    logic [PAT_W-1:0]   led_pat   [NUM_LEDS];
    logic               led_on    [NUM_LEDS];
    logic [PHASE_W-1:0] led_phase [NUM_LEDS];
    logic [MS_W-1:0]    led_ms    [NUM_LEDS];

    logic [LEVELS_W-1:0] levels_q [$];

    function automatic logic [MS_W-1:0] half_period(input logic [PAT_W-1:0] pat);
        logic [MS_W-1:0] v;
        v = (pat == PAT_SLOW) ? slow_ms : fast_ms;
        return (v == '0) ? MS_W'(1) : v;
    endfunction

    function automatic void enter_next_phase(input int i);
        logic [1:0]         s;
        logic [PHASE_W-1:0] p;
        s = 2'(led_pat[i] - PAT_BURST);
        p = led_phase[i];
        if (p >= SEQ_LEN[s])
            p = '0;
        led_on[i] = SEQ_LEVEL[s][p];
        led_ms[i] = SEQ_MS[s][p];
        p = p + 1'b1;
        if (p >= SEQ_LEN[s])
            p = '0;
        led_phase[i] = p;
    endfunction

    function automatic void set_led(input int i, input logic [PAT_W-1:0] pat);
        if (led_pat[i] == pat)
            return;
        led_pat[i] = pat;
        if (pat == PAT_OFF || pat == PAT_ON)
        begin
            led_on[i] = (pat == PAT_ON);
            led_ms[i] = '0;
        end
        else if (pat == PAT_SLOW || pat == PAT_FAST)
        begin
            led_on[i] = 1'b1;
            led_ms[i] = half_period(pat);
        end
        else
        begin
            led_phase[i] = '0;
            enter_next_phase(i);
        end
    endfunction

    function automatic void tick_led(input int i);
        if (led_pat[i] == PAT_OFF || led_pat[i] == PAT_ON)
            return;
        if (led_ms[i] > 1)
        begin
            led_ms[i] = led_ms[i] - 1'b1;
            return;
        end
        if (led_pat[i] == PAT_SLOW || led_pat[i] == PAT_FAST)
        begin
            led_on[i] = ~led_on[i];
            led_ms[i] = half_period(led_pat[i]);
        end
        else
            enter_next_phase(i);
    endfunction

    function automatic logic [LEVELS_W-1:0] next_led_levels(
        input logic               cmd,
        input logic [IDX_W-1:0]   idx,
        input logic [PAT_W-1:0]   pat
    );
        logic [LEVELS_W-1:0] lv;
        lv = '0;
        if (cmd == CMD_TICK)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
                tick_led(i);
        end
        else if (int'(idx) < NUM_LEDS)
            set_led(int'(idx), pat);
        for (int i = 0; i < NUM_LEDS && i < LEVELS_W; i++)
            lv[i] = led_on[i];
        return lv;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [LEVELS_W-1:0] want;
        if (!rst_n)
        begin
            slow_ms = SLOW_RESET;
            fast_ms = FAST_RESET;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                led_pat[i]   = PAT_OFF;
                led_on[i]    = 1'b0;
                led_phase[i] = '0;
                led_ms[i]    = '0;
            end
            levels_q.delete();
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SLOW)
                    slow_ms = cfg_data;
                else if (cfg_index == CFG_FAST)
                    fast_ms = cfg_data;
            end
            if (result.valid && result.ready)
            begin
                if (levels_q.size() == 0)
                begin
                    $error("led_levels: expected none outstanding, actual %h",
                           result.led_levels);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = levels_q.pop_front();
                    if (result.led_levels !== want)
                    begin
                        $error("led_levels: expected %h, actual %h", want, result.led_levels);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (request.valid && request.ready)
                levels_q.push_back(next_led_levels(request.command, request.led_index,
                                                   request.pattern_code));
            pending <= levels_q.size();
        end
    end

endmodule

// File: tb/sv/status_led_pattern_sequencer_test.sv
// Top of the status LED pattern sequencer testbench: clock, reset, requests and verdict
module status_led_pattern_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slps_pkg::*;

    localparam int IDLE_LIMIT = 500;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MS_W-1:0]      cfg_data;

    slps_req_if request ();
    slps_res_if result ();

    int pending;
    int mismatches;
    int gap_max;
    int stall_max;
    int stall_left;
    int burst_left;
    int requests_sent;
    int settings_used;
    int idle_cycles;

    status_led_pattern_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .result    (result)
    );

    status_led_pattern_sequencer_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .request    (request),
        .result     (result),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side stalls on its own random pattern
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            result.ready <= 1'b0;
        end
        else if (stall_max != 0 && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, stall_max - 1);
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request.valid && request.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_request(
        input logic             cmd,
        input logic [IDX_W-1:0] idx,
        input logic [PAT_W-1:0] pat
    );
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0)
            begin
                request.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        request.valid        <= 1'b1;
        request.command      <= cmd;
        request.led_index    <= idx;
        request.pattern_code <= pat;
        do
            @(posedge clk);
        while (!request.ready);
        burst_left--;
        requests_sent++;
    endtask

    task automatic set_pattern(input int idx, input logic [PAT_W-1:0] pat);
        send_request(CMD_SET, IDX_W'(idx), pat);
    endtask

    task automatic tick(input int n);
        repeat (n)
            send_request(CMD_TICK, IDX_W'($urandom), PAT_W'($urandom));
    endtask

    // registers change only once every result is back
    task automatic drain();
        request.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_toggles(input logic [MS_W-1:0] slow, input logic [MS_W-1:0] fast);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SLOW;
        cfg_data  <= slow;
        @(posedge clk);
        cfg_index <= CFG_FAST;
        cfg_data  <= fast;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_phase(
        input logic [MS_W-1:0] slow,
        input logic [MS_W-1:0] fast,
        input int              gaps,
        input int              stalls,
        input int              set_pct,
        input int              n
    );
        drain();
        write_toggles(slow, fast);
        gap_max   = gaps;
        stall_max = stalls;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < set_pct)
                set_pattern($urandom_range(0, 3), PAT_W'($urandom_range(0, 7)));
            else
                tick(1);
        end
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_SLOW;
        cfg_data             = '0;
        request.valid        = 1'b0;
        request.command      = CMD_TICK;
        request.led_index    = '0;
        request.pattern_code = PAT_OFF;
        result.ready         = 1'b0;
        gap_max              = 2;
        stall_max            = 2;
        stall_left           = 0;
        burst_left           = 0;
        requests_sent        = 0;
        settings_used        = 0;
        idle_cycles          = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // zero slow half-period acts as 1 ms, fast at its maximum
        write_toggles(12'd0, 12'd4095);
        tick(1);
        set_pattern(0, PAT_ON);
        set_pattern(0, PAT_ON);
        set_pattern(1, PAT_SLOW);
        set_pattern(2, PAT_FAST);
        set_pattern(3, PAT_BURST);
        tick(3);
        set_pattern(3, PAT_HEART);
        set_pattern(2, PAT_HEARTF);
        set_pattern(1, PAT_URGENT);
        set_pattern(0, PAT_OFF);
        set_pattern(0, PAT_SLOW);
        tick(2);
        set_pattern(2, PAT_URGENT);
        set_pattern(3, PAT_SLOW);
        tick(1);
        set_pattern(1, PAT_OFF);
        set_pattern(3, PAT_ON);
        tick(1);

        random_phase(12'd1, 12'd1, 0, 0, 20, 50);
        random_phase(12'd4095, 12'd4095, 6, 8, 15, 60);
        random_phase(12'd0, 12'd2, 3, 0, 10, 60);
        random_phase(12'd3, 12'd7, 0, 5, 25, 60);
        random_phase(MS_W'($urandom_range(1, 40)), MS_W'($urandom_range(1, 40)),
                     8, 12, 5, 90);
        random_phase(SLOW_RESET, FAST_RESET, 2, 3, 15, 60);

        // long tick run so the urgent sequence wraps
        drain();
        write_toggles(12'd50, 12'd7);
        gap_max   = 4;
        stall_max = 4;
        for (int i = 0; i < 4; i++)
            set_pattern(i, PAT_OFF);
        set_pattern(0, PAT_HEART);
        set_pattern(1, PAT_HEARTF);
        set_pattern(2, PAT_BURST);
        set_pattern(3, PAT_URGENT);
        tick(360);
        set_pattern(2, PAT_SLOW);
        set_pattern(3, PAT_FAST);
        tick(10);

        drain();
        $display("Ran %0d requests: directed patterns, random ticks and sets over %0d",
                 requests_sent, settings_used);
        $display("half-period settings, and a long tick run that wraps the urgent sequence.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
